>>> hw/rtl/cit_pkg.sv
// cit_pkg: shared types, sizes and codes of the coalescing interval table
// used by cit_alu, cit_store and coalescing_interval_table; no dependencies
package cit_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// command codes
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// one stored interval
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] total;
	} entry_t;

	// shared unit operations
	typedef enum logic [1:0] {
		ALU_LT,
		ALU_END_EQ,
		ALU_END_GT,
		ALU_SAT
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} alu_req_t;

	// table memory access for one cycle
	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_data;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CK,
		S_QRY_END,
		S_DECIDE,
		S_MRG_LEN,
		S_MRG_CNT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_UP_RD,
		S_UP_CK,
		S_UP_LEN,
		S_UP_CNT,
		S_PULL_RD,
		S_PULL_WR,
		S_WB
	} state_t;

endpackage

>>> hw/rtl/cit_alu.sv
// cit_alu: shared compare / end-of-interval / saturating add unit
// depends on cit_pkg
module cit_alu (
	input  cit_pkg::alu_req_t req,
	output logic              flag,
	output logic [31:0]       sum
);
	import cit_pkg::*;

	logic [32:0] sum33;

	// one 33-bit adder, never wraps
	assign sum33 = {1'b0, req.a} + {1'b0, req.b};

	// saturated sum
	assign sum = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];

	// flag select
	always_comb begin
		case (req.op)
			ALU_LT:     flag = (req.a < req.b);
			ALU_END_EQ: flag = (sum33 == {1'b0, req.c});
			ALU_END_GT: flag = (sum33 > {1'b0, req.c});
			ALU_SAT:    flag = sum33[32];
			default:    flag = 1'b0;
		endcase
	end

endmodule

>>> hw/rtl/cit_store.sv
// cit_store: interval table memory, one write and one registered read per cycle
// depends on cit_pkg
module cit_store (
	input  logic              clk,
	input  cit_pkg::mem_req_t req,
	output cit_pkg::entry_t   rdata
);
	import cit_pkg::*;

	entry_t mem [TABLE_ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[req.rd_addr];
		end
	end

endmodule

>>> hw/rtl/coalescing_interval_table.sv
// coalescing_interval_table: start-sorted interval table with adjacent merging
// a query or refused add scans the entries in order; other adds then either merge below,
// update a repeated start in place, or insert by moving the higher entries up, then absorb
// each neighbor that begins at the end, pulling later entries down, and write back
// one beat in flight, busy until its result; receiver cannot stall; shared unit, one read port
// reset clears the fill count and sequencer; table words stay undefined and are never read
module coalescing_interval_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] time_point,
	input  logic [31:0] span_length,
	input  logic [31:0] event_count,
	output logic        done,
	output logic        covered,
	output logic        table_full_drop,
	output logic [4:0]  entries_used
);
	import cit_pkg::*;

	state_t   state_q, state_d;
	mem_req_t mem_req;
	alu_req_t alu_req;
	entry_t   rdata;
	logic     alu_flag;
	logic [31:0] alu_sum;

	cnt_t cnt_q, i_q, below_q;
	idx_t idx_q;
	logic done_q, covered_q, drop_q;
	logic [4:0] used_q;

	logic        cmd_q;
	logic [31:0] s_q, len_q, ev_q;
	entry_t      prev_q, cur_q, acc_q, nxt_q, pent;

	logic scan_go, dec_merge, dec_dup, dec_full, up_last, pull_last, finish;
	cnt_t idx_next;

	cit_alu u_alu (
		.req  (alu_req),
		.flag (alu_flag),
		.sum  (alu_sum)
	);

	cit_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// decision terms
	assign pent      = (below_q != '0) ? prev_q : cur_q;
	assign scan_go   = (cmd_q == CMD_ADD) ? alu_flag : !alu_flag;
	assign dec_merge = (cnt_q != '0) && alu_flag;
	assign dec_dup   = (below_q < cnt_q) && (cur_q.start == s_q);
	assign dec_full  = (cnt_q == CNT_W'(TABLE_ENTRIES));
	assign idx_next  = CNT_W'(idx_q) + 1'b1;
	assign up_last   = (idx_next >= cnt_q);
	assign pull_last = ((i_q + 1'b1) >= cnt_q);
	assign finish    = (state_q == S_QRY_END) || (state_q == S_WB) ||
		((state_q == S_DECIDE) && !dec_merge && !dec_dup && dec_full);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, memory and shared unit requests
	always_comb begin
		state_d = state_q;
		mem_req = '0;
		alu_req = '{op: ALU_LT, a: '0, b: '0, c: '0};
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (i_q == cnt_q) begin
					state_d = (cmd_q == CMD_QUERY) ? S_QRY_END : S_DECIDE;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = i_q[IDX_W-1:0];
					state_d         = S_SCAN_CK;
				end
			end
			S_SCAN_CK: begin
				if (cmd_q == CMD_ADD) begin
					alu_req = '{op: ALU_LT, a: rdata.start, b: s_q, c: '0};
				end else begin
					alu_req = '{op: ALU_LT, a: s_q, b: rdata.start, c: '0};
				end
				if (scan_go) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = (cmd_q == CMD_QUERY) ? S_QRY_END : S_DECIDE;
				end
			end
			S_QRY_END: begin
				alu_req = '{op: ALU_END_GT, a: prev_q.start, b: prev_q.length, c: s_q};
				state_d = S_IDLE;
			end
			S_DECIDE: begin
				alu_req = '{op: ALU_END_EQ, a: pent.start, b: pent.length, c: s_q};
				if (dec_merge) begin
					state_d = S_MRG_LEN;
				end else if (dec_dup) begin
					state_d = S_UP_RD;
				end else if (dec_full) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_MRG_LEN: begin
				alu_req = '{op: ALU_SAT, a: acc_q.length, b: len_q, c: '0};
				state_d = S_MRG_CNT;
			end
			S_MRG_CNT: begin
				alu_req = '{op: ALU_SAT, a: acc_q.total, b: ev_q, c: '0};
				state_d = S_UP_RD;
			end
			S_SHIFT_RD: begin
				if (i_q == below_q) begin
					state_d = S_UP_RD;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = IDX_W'(i_q - 1'b1);
					state_d         = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q[IDX_W-1:0];
				mem_req.wr_data = rdata;
				state_d         = S_SHIFT_RD;
			end
			S_UP_RD: begin
				if (up_last) begin
					state_d = S_WB;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = idx_next[IDX_W-1:0];
					state_d         = S_UP_CK;
				end
			end
			S_UP_CK: begin
				alu_req = '{op: ALU_END_EQ, a: acc_q.start, b: acc_q.length, c: rdata.start};
				state_d = alu_flag ? S_UP_LEN : S_WB;
			end
			S_UP_LEN: begin
				alu_req = '{op: ALU_SAT, a: acc_q.length, b: nxt_q.length, c: '0};
				state_d = S_UP_CNT;
			end
			S_UP_CNT: begin
				alu_req = '{op: ALU_SAT, a: acc_q.total, b: nxt_q.total, c: '0};
				state_d = S_PULL_RD;
			end
			S_PULL_RD: begin
				if (pull_last) begin
					state_d = S_UP_RD;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = IDX_W'(i_q + 1'b1);
					state_d         = S_PULL_WR;
				end
			end
			S_PULL_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q[IDX_W-1:0];
				mem_req.wr_data = rdata;
				state_d         = S_PULL_RD;
			end
			S_WB: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = idx_q;
				mem_req.wr_data = acc_q;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// counters, indexes and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			i_q       <= '0;
			below_q   <= '0;
			idx_q     <= '0;
			done_q    <= 1'b0;
			covered_q <= 1'b0;
			drop_q    <= 1'b0;
			used_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) i_q <= '0;
				end
				S_SCAN_RD: begin
					if (i_q == cnt_q) below_q <= i_q;
				end
				S_SCAN_CK: begin
					if (scan_go) i_q <= i_q + 1'b1;
					else below_q <= i_q;
				end
				S_DECIDE: begin
					if (dec_merge) begin
						idx_q <= (below_q != '0) ? IDX_W'(below_q - 1'b1) : '0;
					end else if (dec_dup) begin
						idx_q <= below_q[IDX_W-1:0];
					end else if (!dec_full) begin
						idx_q <= below_q[IDX_W-1:0];
						i_q   <= cnt_q;
					end
				end
				S_SHIFT_RD: begin
					if (i_q == below_q) cnt_q <= cnt_q + 1'b1;
				end
				S_SHIFT_WR: i_q <= i_q - 1'b1;
				S_UP_CNT:   i_q <= idx_next;
				S_PULL_RD: begin
					if (pull_last) cnt_q <= cnt_q - 1'b1;
				end
				S_PULL_WR:  i_q <= i_q + 1'b1;
				default: ;
			endcase
			done_q <= finish;
			if (finish) begin
				covered_q <= (state_q == S_QRY_END) && (below_q != '0) && alu_flag;
				drop_q    <= (state_q == S_DECIDE);
				used_q    <= 5'(cnt_q);
			end
		end
	end

	// beat payload and working entries
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= command;
					s_q   <= time_point;
					len_q <= span_length;
					ev_q  <= event_count;
				end
			end
			S_SCAN_CK: begin
				if (scan_go) prev_q <= rdata;
				else cur_q <= rdata;
			end
			S_DECIDE: begin
				if (dec_merge) acc_q <= pent;
				else if (dec_dup) acc_q <= cur_q;
				else acc_q <= '{start: s_q, length: len_q, total: ev_q};
			end
			S_MRG_LEN, S_UP_LEN: acc_q.length <= alu_sum;
			S_MRG_CNT, S_UP_CNT: acc_q.total  <= alu_sum;
			S_UP_CK: nxt_q <= rdata;
			default: ;
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign covered         = covered_q;
	assign table_full_drop = drop_q;
	assign entries_used    = used_q;

	// result beat only comes out once the sequencer is back at rest
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result beat while busy");

	// fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count overflow");

	// a refused add only happens on a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full_drop) |-> (cnt_q == CNT_W'(TABLE_ENTRIES)))
		else $error("drop flagged with room left");

	// coverage answer only for a query beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && covered) |-> (cmd_q == CMD_QUERY))
		else $error("covered set on an add");

	// an accepted beat makes the block busy next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted beat did not start the sequencer");

endmodule

>>> tb/coalescing_interval_table_test.sv
// coalescing_interval_table_test: self-checking bench for the interval table
// depends on cit_pkg and coalescing_interval_table; a driver, a monitor and an
// in-bench table model that predicts every result beat
`timescale 1ns / 1ps

module coalescing_interval_table_test;
	import cit_pkg::*;

	localparam int RANDOM_BEATS = 1330;
	localparam int TAIL_CYCLES = 64;

	// whole table as one value so it can be advanced by a pure function
	typedef struct packed {
		entry_t [TABLE_ENTRIES-1:0] ent;
		cnt_t                       fill;
	} span_table_t;

	typedef struct packed {
		logic       covered;
		logic       full_drop;
		logic [4:0] used;
	} outcome_t;

	typedef struct packed {
		span_table_t tbl;
		outcome_t    res;
	} table_step_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] tp;
		logic [31:0] len;
		logic [31:0] cnt;
		logic        hold;
	} sample_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        command = CMD_ADD;
	logic [31:0] time_point = '0;
	logic [31:0] span_length = '0;
	logic [31:0] event_count = '0;
	logic        busy;
	logic        done;
	logic        covered;
	logic        table_full_drop;
	logic [4:0]  entries_used;

	sample_beat_t pending_beats[$];
	outcome_t     expected_outcomes[$];
	span_table_t  plan_tbl;
	span_table_t  live_tbl;
	logic [31:0]  zone_base;
	int           outstanding = 0;
	int           idle_left = 0;
	int           calm_left = 0;
	int           mismatches = 0;

	coalescing_interval_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.time_point      (time_point),
		.span_length     (span_length),
		.event_count     (event_count),
		.done            (done),
		.covered         (covered),
		.table_full_drop (table_full_drop),
		.entries_used    (entries_used)
	);

	always #10 clk = ~clk;

	// exclusive end of an interval, never wraps
	function automatic logic [32:0] end_at(entry_t e);
		return {1'b0, e.start} + {1'b0, e.length};
	endfunction

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// apply one beat to a table, return the new table and the result
	function automatic table_step_t advance(span_table_t t, logic cmd, logic [31:0] tp,
			logic [31:0] len, logic [31:0] cnt);
		table_step_t r;
		int below;
		int p;
		int idx;
		int k;
		int n;
		r.res = '0;
		if (cmd == CMD_ADD) begin
			below = 0;
			while (below < t.fill && t.ent[below].start < tp)
				below++;
			p = (below > 0) ? below - 1 : 0;
			idx = -1;
			if (t.fill > 0 && end_at(t.ent[p]) == {1'b0, tp}) begin
				t.ent[p].length = sat_sum(t.ent[p].length, len);
				t.ent[p].total = sat_sum(t.ent[p].total, cnt);
				idx = p;
			end else if (below < t.fill && t.ent[below].start == tp) begin
				idx = below;
			end else if (t.fill >= TABLE_ENTRIES) begin
				r.res.full_drop = 1'b1;
			end else begin
				for (k = t.fill; k > below; k--)
					t.ent[k] = t.ent[k-1];
				t.ent[below] = {tp, len, cnt};
				t.fill = t.fill + 1'b1;
				idx = below;
			end
			// absorb following neighbors that begin exactly at the end
			if (idx >= 0) begin
				while (idx + 1 < t.fill && end_at(t.ent[idx]) == {1'b0, t.ent[idx+1].start}) begin
					t.ent[idx].length = sat_sum(t.ent[idx].length, t.ent[idx+1].length);
					t.ent[idx].total = sat_sum(t.ent[idx].total, t.ent[idx+1].total);
					for (k = idx + 1; k + 1 < t.fill; k++)
						t.ent[k] = t.ent[k+1];
					t.fill = t.fill - 1'b1;
				end
			end
		end else begin
			n = 0;
			while (n < t.fill && t.ent[n].start <= tp)
				n++;
			if (n > 0)
				r.res.covered = ({1'b0, tp} < end_at(t.ent[n-1]));
		end
		r.res.used = 5'(t.fill);
		r.tbl = t;
		return r;
	endfunction

	// idle length before the next beat: mostly short, some long, some calm runs
	function automatic int next_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	task automatic queue_beat(logic cmd, logic [31:0] tp, logic [31:0] len,
			logic [31:0] cnt, logic hold);
		table_step_t s;
		pending_beats.push_back({cmd, tp, len, cnt, hold});
		s = advance(plan_tbl, cmd, tp, len, cnt);
		plan_tbl = s.tbl;
	endtask

	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom;
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	// random beat steered by the planned table contents
	task automatic queue_random_beat(logic hold);
		int r;
		int i;
		int k;
		int nf;
		int gaps[$];
		logic [32:0] e;
		logic        cmd;
		logic [31:0] tp;
		logic [31:0] len;
		logic [31:0] cnt;
		nf = plan_tbl.fill;
		cmd = logic'($urandom_range(0, 1));
		tp = $urandom;
		len = $urandom;
		cnt = $urandom;
		i = (nf > 0) ? $urandom_range(0, nf - 1) : 0;
		e = end_at(plan_tbl.ent[i]);
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// noise: every field fully random
		end else if (r < 35) begin
			cmd = CMD_QUERY;
			if (nf > 0) begin
				case ($urandom_range(0, 4))
					0: tp = plan_tbl.ent[i].start;
					1: tp = e[31:0] - 32'd1;
					2: tp = e[31:0];
					3: tp = plan_tbl.ent[i].start - 32'd1;
					default: tp = plan_tbl.ent[i].start + $urandom_range(0, 300);
				endcase
			end
		end else begin
			cmd = CMD_ADD;
			len = pick_length();
			if ($urandom_range(0, 3) != 0)
				cnt = $urandom_range(0, 1000);
			for (k = 0; k + 1 < nf; k++)
				if (end_at(plan_tbl.ent[k]) < {1'b0, plan_tbl.ent[k+1].start})
					gaps.push_back(k);
			tp = zone_base + $urandom_range(0, 4095);
			r = $urandom_range(0, 99);
			if (nf == 0 || r < 5 || r < 5 + (TABLE_ENTRIES - nf) * 4) begin
				// fresh start near the current zone
			end else if (gaps.size() > 0 && r < 70) begin
				k = gaps[$urandom_range(0, gaps.size() - 1)];
				e = end_at(plan_tbl.ent[k]);
				tp = e[31:0];
				len = plan_tbl.ent[k+1].start - e[31:0];
			end else if (r < 90) begin
				if (!e[32])
					tp = e[31:0];
			end else begin
				tp = plan_tbl.ent[i].start;
			end
		end
		queue_beat(cmd, tp, len, cnt, hold);
	endtask

	// driver: offer beats, predict each one at the edge it is taken
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic         taken;
		sample_beat_t nxt;
		table_step_t  s;
		if (!arst_n) begin
			start <= 1'b0;
			command <= CMD_ADD;
			time_point <= '0;
			span_length <= '0;
			event_count <= '0;
			live_tbl = '0;
			outstanding = 0;
			idle_left = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				s = advance(live_tbl, command, time_point, span_length, event_count);
				live_tbl = s.tbl;
				expected_outcomes.push_back(s.res);
			end
			outstanding = outstanding + int'(taken) - int'(done);
			if (!(start && !taken)) begin
				if (idle_left > 0) begin
					start <= 1'b0;
					idle_left = idle_left - 1;
				end else if (pending_beats.size() == 0) begin
					start <= 1'b0;
				end else if (pending_beats[0].hold && outstanding != 0) begin
					start <= 1'b0;
				end else begin
					nxt = pending_beats.pop_front();
					command <= nxt.cmd;
					time_point <= nxt.tp;
					span_length <= nxt.len;
					event_count <= nxt.cnt;
					start <= 1'b1;
					idle_left = next_gap();
				end
			end
		end
	end

	// monitor: each result beat against the oldest expectation
	always @(posedge clk) begin : watch_proc
		outcome_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("result beat with no pending command: covered=%0b drop=%0b used=%0d",
					covered, table_full_drop, entries_used);
				mismatches++;
			end else begin
				want = expected_outcomes.pop_front();
				if (covered !== want.covered) begin
					$error("covered: expected %0b, got %0b", want.covered, covered);
					mismatches++;
				end
				if (table_full_drop !== want.full_drop) begin
					$error("table_full_drop: expected %0b, got %0b", want.full_drop,
						table_full_drop);
					mismatches++;
				end
				if (entries_used !== want.used) begin
					$error("entries_used: expected %0d, got %0d", want.used, entries_used);
					mismatches++;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		plan_tbl = '0;
		zone_base = $urandom;

		// directed: empty query, insert, merge, adjacency, repeats, saturation, top end
		queue_beat(CMD_QUERY, 32'd0, 32'd0, 32'd0, 1'b0);
		queue_beat(CMD_ADD, 32'd100, 32'd50, 32'd5, 1'b0);
		queue_beat(CMD_ADD, 32'd150, 32'd10, 32'd7, 1'b0);
		queue_beat(CMD_QUERY, 32'd100, 32'd0, 32'd0, 1'b0);
		queue_beat(CMD_QUERY, 32'd159, 32'd0, 32'd0, 1'b0);
		queue_beat(CMD_QUERY, 32'd160, 32'd0, 32'd0, 1'b0);
		queue_beat(CMD_QUERY, 32'd99, 32'd0, 32'd0, 1'b0);
		queue_beat(CMD_ADD, 32'd200, 32'd20, 32'd1, 1'b0);
		queue_beat(CMD_ADD, 32'd160, 32'd40, 32'd2, 1'b0);
		queue_beat(CMD_ADD, 32'd100, 32'd5, 32'd3, 1'b1);
		queue_beat(CMD_ADD, 32'd50, 32'd50, 32'd4, 1'b0);
		queue_beat(CMD_ADD, 32'hF000_0000, 32'h0800_0000, 32'd1, 1'b0);
		queue_beat(CMD_ADD, 32'hF800_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_beat(CMD_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
		queue_beat(CMD_ADD, 32'hFFFF_FF00, 32'h0000_0100, 32'd0, 1'b0);
		queue_beat(CMD_ADD, 32'hFFFF_FFFF, 32'd1, 32'd9, 1'b0);
		queue_beat(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_beat(CMD_ADD, 32'd0, 32'd0, 32'd0, 1'b1);
		queue_beat(CMD_ADD, 32'd0, 32'd7, 32'd2, 1'b0);
		queue_beat(CMD_QUERY, 32'd6, 32'd0, 32'd0, 1'b0);

		// random: move to a new zone now and then, drain the pipe every so often
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 150 == 149)
				zone_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom;
			queue_random_beat(n % 250 == 249);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() > 0 || start || expected_outcomes.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#100000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
